@@ rtl/core/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcw_pkg;

	localparam logic [7:0] SPACE_CHAR   = 8'd32;
	localparam logic [7:0] NEWLINE_CHAR = 8'd10;
	localparam logic [7:0] ZERO_BYTE    = 8'd0;

	typedef enum logic [2:0] {
		OP_PRINT       = 3'd0,
		OP_PRINT_COLOR = 3'd1,
		OP_CLEAR       = 3'd2,
		OP_FILL        = 3'd3,
		OP_READ        = 3'd4
	} op_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_SCROLL,
		ST_BLANK,
		ST_PRINT,
		ST_CLEAR,
		ST_FILL,
		ST_READ,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic in_ready;
		logic accept;
		logic cnt_inc;
		logic init_wr;
		logic copy_rd;
		logic blank_wr;
		logic cursor_scroll;
		logic print_step;
		logic clear_wr;
		logic cursor_home;
		logic fill_wr;
		logic read_rd;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		op_t  in_op;
		logic cursor_end;
		logic cnt_scroll_last;
		logic cnt_last;
		logic out_free;
	} status_t;

endpackage

@@ rtl/core/tcw_ctrl.sv @@
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer for the console: reset sweep, scroll, clear, fill, print, read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcw_ctrl
	import tcw_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_INIT: begin
				cmd.init_wr = 1'b1;
				cmd.cnt_inc = 1'b1;
				if (status.cnt_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				cmd.in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					unique case (status.in_op)
						OP_PRINT, OP_PRINT_COLOR: begin
							state_d = status.cursor_end ? ST_SCROLL : ST_PRINT;
						end
						OP_CLEAR: state_d = ST_CLEAR;
						OP_FILL:  state_d = ST_FILL;
						OP_READ:  state_d = ST_READ;
						default:  state_d = ST_RESULT;
					endcase
				end
			end
			ST_SCROLL: begin
				// the last count issues no read; it drains the pending copy write
				if (status.cnt_scroll_last) begin
					state_d = ST_BLANK;
				end else begin
					cmd.copy_rd = 1'b1;
					cmd.cnt_inc = 1'b1;
				end
			end
			ST_BLANK: begin
				cmd.blank_wr = 1'b1;
				cmd.cnt_inc  = 1'b1;
				if (status.cnt_last) begin
					cmd.cursor_scroll = 1'b1;
					state_d           = ST_PRINT;
				end
			end
			ST_PRINT: begin
				cmd.print_step = 1'b1;
				state_d        = ST_RESULT;
			end
			ST_CLEAR: begin
				cmd.clear_wr = 1'b1;
				cmd.cnt_inc  = 1'b1;
				if (status.cnt_last) begin
					cmd.cursor_home = 1'b1;
					state_d         = ST_RESULT;
				end
			end
			ST_FILL: begin
				cmd.fill_wr = 1'b1;
				cmd.cnt_inc = 1'b1;
				if (status.cnt_last) state_d = ST_RESULT;
			end
			ST_READ: begin
				cmd.read_rd = 1'b1;
				state_d     = ST_RESULT;
			end
			ST_RESULT: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_INIT;
		endcase
	end

endmodule

@@ rtl/core/tcw_datapath.sv @@
// ----------------------------------------------------------------------------
// tcw_datapath
// Character and attribute memories, sweep counter, cursor and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcw_datapath
	import tcw_pkg::*;
#(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25,
	parameter int CW      = 11,
	parameter int IN_W    = 32,
	parameter int OUT_W   = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [2:0]       in_user,
	input  logic [IN_W-1:0]  in_data,
	input  logic             out_ready,
	output logic             out_valid,
	output logic [OUT_W-1:0] out_data,
	input  cmd_t             cmd,
	output status_t          status
);

	localparam int CELLS  = COLUMNS * ROWS;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int COL_W  = $clog2(COLUMNS);
	localparam int OUT_DW = CW + 17;

	logic [7:0] char_mem [CELLS];
	logic [7:0] attr_mem [CELLS];

	op_t               op_q;
	logic [7:0]        ch_q;
	logic [7:0]        color_q;
	logic [CW-1:0]     idx_q;
	logic [ADDR_W-1:0] cnt_q;
	logic [CW-1:0]     cell_q;
	logic [COL_W-1:0]  col_q;
	logic              scrolled_q;
	logic              copy_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [7:0]        crd_q;
	logic [7:0]        ard_q;
	logic              out_valid_q;
	logic [OUT_W-1:0]  out_data_q;

	logic              idx_ok;
	logic              c_we, a_we, c_re, a_re;
	logic [ADDR_W-1:0] c_wa, a_wa, c_ra;
	logic [7:0]        c_wd, a_wd;
	logic [7:0]        res_char, res_color;
	logic [OUT_DW-1:0] res_word;

	assign idx_ok = idx_q < CW'(CELLS);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q    <= op_t'(in_user);
			ch_q    <= in_data[7:0];
			color_q <= in_data[15:8];
			idx_q   <= in_data[16 +: CW];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			cell_q     <= '0;
			col_q      <= '0;
			scrolled_q <= 1'b0;
			copy_s1    <= 1'b0;
		end else begin
			copy_s1 <= cmd.copy_rd;
			if (cmd.accept) begin
				cnt_q      <= '0;
				scrolled_q <= 1'b0;
			end else if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + ADDR_W'(1);
			end
			if (cmd.cursor_scroll) begin
				cell_q     <= CW'(CELLS - COLUMNS);
				col_q      <= '0;
				scrolled_q <= 1'b1;
			end else if (cmd.cursor_home) begin
				cell_q <= '0;
				col_q  <= '0;
			end else if (cmd.print_step) begin
				if (ch_q == NEWLINE_CHAR) begin
					cell_q <= cell_q + CW'(COLUMNS) - CW'(col_q);
					col_q  <= '0;
				end else begin
					cell_q <= cell_q + CW'(1);
					col_q  <= (col_q == COL_W'(COLUMNS - 1)) ? '0 : col_q + COL_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= cnt_q;
	end

	// char port: the scroll copy write from the pipeline has priority
	always_comb begin
		c_we = 1'b0;
		c_wa = cnt_q;
		c_wd = SPACE_CHAR;
		if (copy_s1) begin
			c_we = 1'b1;
			c_wa = addr_s1;
			c_wd = crd_q;
		end else if (cmd.init_wr) begin
			c_we = 1'b1;
			c_wd = ZERO_BYTE;
		end else if (cmd.blank_wr || cmd.clear_wr) begin
			c_we = 1'b1;
		end else if (cmd.print_step && ch_q != NEWLINE_CHAR) begin
			c_we = 1'b1;
			c_wa = cell_q[ADDR_W-1:0];
			c_wd = ch_q;
		end
	end

	always_comb begin
		a_we = 1'b0;
		a_wa = cnt_q;
		a_wd = color_q;
		if (cmd.init_wr) begin
			a_we = 1'b1;
			a_wd = ZERO_BYTE;
		end else if (cmd.fill_wr) begin
			a_we = 1'b1;
		end else if (cmd.print_step && ch_q != NEWLINE_CHAR && op_q == OP_PRINT_COLOR) begin
			a_we = 1'b1;
			a_wa = cell_q[ADDR_W-1:0];
		end
	end

	assign c_re = cmd.copy_rd || (cmd.read_rd && idx_ok);
	assign a_re = cmd.read_rd && idx_ok;
	assign c_ra = cmd.read_rd ? idx_q[ADDR_W-1:0] : cnt_q + ADDR_W'(COLUMNS);

	always_ff @(posedge clk) begin
		if (c_we) char_mem[c_wa] <= c_wd;
		if (c_re) crd_q <= char_mem[c_ra];
	end

	always_ff @(posedge clk) begin
		if (a_we) attr_mem[a_wa] <= a_wd;
		if (a_re) ard_q <= attr_mem[idx_q[ADDR_W-1:0]];
	end

	assign res_char  = (op_q == OP_READ && idx_ok) ? crd_q : ZERO_BYTE;
	assign res_color = (op_q == OP_READ && idx_ok) ? ard_q : ZERO_BYTE;
	assign res_word  = {scrolled_q, res_color, res_char, cell_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) out_data_q <= OUT_W'(res_word);
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	assign status.in_op           = op_t'(in_user);
	assign status.cursor_end      = cell_q >= CW'(CELLS);
	assign status.cnt_scroll_last = cnt_q == ADDR_W'(CELLS - COLUMNS);
	assign status.cnt_last        = cnt_q == ADDR_W'(CELLS - 1);
	assign status.out_free        = !out_valid_q || out_ready;

endmodule

@@ rtl/core/text_console_writer.sv @@
// ----------------------------------------------------------------------------
// text_console_writer
// Text screen of COLUMNS x ROWS character and attribute cells with a cursor.
// ----------------------------------------------------------------------------
// Input stream s_*: s_tuser carries the operation (print, print with color,
// clear, fill color, read cell); s_tdata carries the character, color and
// cell index. Each transfer yields exactly one result on m_*: the cursor
// after the operation, the read cell's character and attribute (zero unless
// a read) and a flag that the screen scrolled.
// One item is in work at a time. Steps from accept to result:
//   print, read ............. the print or read step
//   print that scrolls ...... row copy, bottom-row blank, print (one cell
//                             copied per cycle, limited by the single write port)
//   clear, fill ............. a sweep of all cells (one cell written per cycle)
//   unused code ............. straight to the result
// After reset both stores are swept to zero, one cell per cycle, over all
// COLUMNS*ROWS cells; s_tready stays low meanwhile.
// The result sits in an output register; when m_tready is low it holds and
// the block takes the next item, stalling only when a new result is ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_console_writer
	import tcw_pkg::*;
#(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25,
	parameter int CW      = $clog2(COLUMNS * ROWS + 1),
	parameter int IN_W    = 8 * ((16 + CW + 7) / 8),
	parameter int OUT_W   = 8 * ((CW + 17 + 7) / 8)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,  // character[7:0], color[15:8], cell_index
	input  logic [2:0]       s_tuser,  // operation
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata   // cursor_cell, read_char, read_color, scrolled
);

	cmd_t    cmd;
	status_t status;

	tcw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.status   (status),
		.cmd      (cmd)
	);

	tcw_datapath #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS),
		.CW      (CW),
		.IN_W    (IN_W),
		.OUT_W   (OUT_W)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_user   (s_tuser),
		.in_data   (s_tdata),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_data  (m_tdata),
		.cmd       (cmd),
		.status    (status)
	);

	assign s_tready = cmd.in_ready;

endmodule

@@ rtl/core/tcw_checker.sv @@
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks of the text console writer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcw_checker #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25,
	parameter int CW      = 11,
	parameter int IN_W    = 32,
	parameter int OUT_W   = 32
) (
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic [IN_W-1:0]  s_tdata,
	input logic [2:0]       s_tuser,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata
);

	localparam int CELLS = COLUMNS * ROWS;

	logic [CW-1:0] cur;
	logic          scr;

	assign cur = m_tdata[CW-1:0];
	assign scr = m_tdata[CW + 16];

	// one item in work at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an item is in work");

	a_in_known: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid |-> !$isunknown({s_tuser, s_tdata}))
		else $error("input transfer carries unknown bits");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> cur <= CW'(CELLS))
		else $error("cursor beyond screen end");

	// a scroll leaves the cursor on the bottom row or just past it
	a_scroll_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && scr |-> cur == CW'(CELLS - COLUMNS + 1) || cur == CW'(CELLS))
		else $error("cursor inconsistent with scroll");

endmodule

bind text_console_writer tcw_checker #(
	.COLUMNS (COLUMNS),
	.ROWS    (ROWS),
	.CW      (CW),
	.IN_W    (IN_W),
	.OUT_W   (OUT_W)
) u_tcw_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
